// ===== design/bnc_pkg.sv =====
package bnc_pkg;

	localparam int STACK_DEPTH_DEF = 128;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int WEIGHT_W        = 16;
	localparam int SCORE_W         = 32;

	localparam logic [1:0] KIND_ROUND  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;
	localparam logic [1:0] KIND_ANGLE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ROUND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SQUARE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CURLY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ANGLE  = 2'd3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
	localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
	localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
	localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

	typedef struct packed {
		logic       line_start;
		logic       is_open;
		logic       is_close;
		logic [1:0] kind;
	} op_t;

endpackage

// ===== design/bracket_nesting_checker.sv =====
// Bracket nesting checker: one character beat in, one result beat out, at a sustained
// rate of one item per clock cycle while out_stall is low. A beat passes through the
// input queue and then the output register before its result shows; the sustained
// rate is set by the stack, whose top entry sits in a register and whose next-lower
// entry is read ahead from the stack RAM every cycle. line_start clears the stack and
// the halt flag before its symbol is looked at. A mismatched or unmatched closer adds
// its weight to the saturating score and skips the rest of the line. A push onto a full
// stack is dropped and sets the sticky overflow flag. Weights must be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module bracket_nesting_checker #(
	parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnc_pkg::WEIGHT_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     symbol,
	input  logic                           line_start,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           mismatch,
	output logic                           line_halted,
	output logic [bnc_pkg::SCORE_W-1:0]    total_score,
	output logic                           overflow
);
	import bnc_pkg::*;

	op_t  enq_op;
	op_t  deq_op;
	logic full;
	logic deq_valid;
	logic deq;
	logic enq;

	assign in_stall = full;
	assign enq      = in_valid && !full;

	bnc_front u_front (
		.symbol     (symbol),
		.line_start (line_start),
		.op         (enq_op)
	);

	bnc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_op    (enq_op),
		.full      (full),
		.deq_valid (deq_valid),
		.deq       (deq),
		.deq_op    (deq_op)
	);

	bnc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op_valid    (deq_valid),
		.op          (deq_op),
		.op_take     (deq),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mismatch    (mismatch),
		.line_halted (line_halted),
		.total_score (total_score),
		.overflow    (overflow)
	);

endmodule

// ===== design/bnc_front.sv =====
module bnc_front (
	input  logic [7:0]     symbol,
	input  logic           line_start,
	output bnc_pkg::op_t   op
);
	import bnc_pkg::*;

	always_comb begin
		op            = '0;
		op.line_start = line_start;
		case (symbol)
			CH_OPEN_ROUND: begin
				op.is_open = 1'b1;
				op.kind    = KIND_ROUND;
			end
			CH_OPEN_SQUARE: begin
				op.is_open = 1'b1;
				op.kind    = KIND_SQUARE;
			end
			CH_OPEN_CURLY: begin
				op.is_open = 1'b1;
				op.kind    = KIND_CURLY;
			end
			CH_OPEN_ANGLE: begin
				op.is_open = 1'b1;
				op.kind    = KIND_ANGLE;
			end
			CH_CLOSE_ROUND: begin
				op.is_close = 1'b1;
				op.kind     = KIND_ROUND;
			end
			CH_CLOSE_SQUARE: begin
				op.is_close = 1'b1;
				op.kind     = KIND_SQUARE;
			end
			CH_CLOSE_CURLY: begin
				op.is_close = 1'b1;
				op.kind     = KIND_CURLY;
			end
			CH_CLOSE_ANGLE: begin
				op.is_close = 1'b1;
				op.kind     = KIND_ANGLE;
			end
			default: begin
				op.kind = KIND_ROUND;
			end
		endcase
	end

endmodule

// ===== design/bnc_queue.sv =====
module bnc_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         enq,
	input  bnc_pkg::op_t enq_op,
	output logic         full,
	output logic         deq_valid,
	input  logic         deq,
	output bnc_pkg::op_t deq_op
);
	import bnc_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	op_t            entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;

	assign full      = (fill_q == QCW'(QUEUE_DEPTH));
	assign deq_valid = (fill_q != '0);
	assign deq_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= enq_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			case ({enq, deq})
				2'b10:   fill_q <= fill_q + QCW'(1);
				2'b01:   fill_q <= fill_q - QCW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/bnc_back.sv =====
module bnc_back #(
	parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnc_pkg::WEIGHT_W-1:0]   cfg_data,
	input  logic                           op_valid,
	input  bnc_pkg::op_t                   op,
	output logic                           op_take,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           mismatch,
	output logic                           line_halted,
	output logic [bnc_pkg::SCORE_W-1:0]    total_score,
	output logic                           overflow
);
	import bnc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [1:0]          mem [STACK_DEPTH];
	logic [1:0]          rd_q;
	logic [1:0]          top_q;
	logic [CW-1:0]       cnt_q;
	logic                halt_q;
	logic                ovf_q;
	logic [SCORE_W-1:0]  score_q;
	logic [WEIGHT_W-1:0] weight_q [4];

	logic                out_valid_q;
	logic                mismatch_q;
	logic                halted_q;
	logic [SCORE_W-1:0]  total_q;
	logic                overflow_q;

	logic                adv;
	logic [CW-1:0]       cnt_eff;
	logic [CW-1:0]       cnt_n;
	logic [CW-1:0]       rd_cnt;
	logic                halt_eff;
	logic                halt_n;
	logic                ovf_n;
	logic [1:0]          top_n;
	logic [SCORE_W-1:0]  score_n;
	logic [SCORE_W:0]    sum;
	logic                bad;
	logic                wr_en;

	assign adv     = op_valid && (!out_valid_q || !out_stall);
	assign op_take = adv;
	assign sum     = {1'b0, score_q} + (SCORE_W + 1)'(weight_q[op.kind]);
	assign rd_cnt  = cnt_n - CW'(2);

	always_comb begin
		cnt_eff  = cnt_q;
		halt_eff = halt_q;
		cnt_n    = cnt_q;
		halt_n   = halt_q;
		ovf_n    = ovf_q;
		top_n    = top_q;
		score_n  = score_q;
		bad      = 1'b0;
		wr_en    = 1'b0;
		if (adv) begin
			cnt_eff  = op.line_start ? '0 : cnt_q;
			halt_eff = op.line_start ? 1'b0 : halt_q;
			cnt_n    = cnt_eff;
			halt_n   = halt_eff;
			if (!halt_eff) begin
				if (op.is_open) begin
					if (cnt_eff < CW'(STACK_DEPTH)) begin
						wr_en = 1'b1;
						top_n = op.kind;
						cnt_n = cnt_eff + CW'(1);
					end else begin
						ovf_n = 1'b1;
					end
				end else if (op.is_close) begin
					if (cnt_eff == '0) begin
						bad = 1'b1;
					end else begin
						cnt_n = cnt_eff - CW'(1);
						top_n = rd_q;
						bad   = (top_q != op.kind);
					end
					if (bad) begin
						score_n = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
						halt_n  = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_eff[AW-1:0]] <= op.kind;
		end
		rd_q <= mem[rd_cnt[AW-1:0]];
		top_q <= top_n;
		if (adv) begin
			mismatch_q <= bad;
			halted_q   <= halt_n;
			total_q    <= score_n;
			overflow_q <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			halt_q      <= 1'b0;
			ovf_q       <= 1'b0;
			score_q     <= '0;
			out_valid_q <= 1'b0;
			weight_q[REG_WEIGHT_ROUND]  <= WEIGHT_ROUND_RST;
			weight_q[REG_WEIGHT_SQUARE] <= WEIGHT_SQUARE_RST;
			weight_q[REG_WEIGHT_CURLY]  <= WEIGHT_CURLY_RST;
			weight_q[REG_WEIGHT_ANGLE]  <= WEIGHT_ANGLE_RST;
		end else begin
			cnt_q   <= cnt_n;
			halt_q  <= halt_n;
			ovf_q   <= ovf_n;
			score_q <= score_n;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				weight_q[cfg_index] <= cfg_data;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign mismatch    = mismatch_q;
	assign line_halted = halted_q;
	assign total_score = total_q;
	assign overflow    = overflow_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_mismatch_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mismatch_q |-> halted_q)
		else $error("mismatch beat without halted line");

	a_score_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> score_q >= $past(score_q))
		else $error("score decreased");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bnc_pkg::*;

	typedef struct packed {
		logic               mismatch;
		logic               line_halted;
		logic [SCORE_W-1:0] total_score;
		logic               overflow;
	} line_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WEIGHT_ROUND;
	logic [WEIGHT_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           symbol = 8'h00;
	logic                 line_start = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 mismatch;
	logic                 line_halted;
	logic [SCORE_W-1:0]   total_score;
	logic                 overflow;

	logic [WEIGHT_W-1:0]  weight_q [4];
	logic [1:0]           kind_stack [STACK_DEPTH_DEF];
	int                   stack_fill = 0;
	logic                 line_dead = 1'b0;
	logic [SCORE_W-1:0]   score_acc = '0;
	logic                 stack_ovf = 1'b0;
	line_result_t         pending_results [$];

	int                   err_cnt = 0;
	int                   beats_sent = 0;
	int                   beats_checked = 0;
	bit                   src_idle_en = 1'b1;
	bit                   snk_idle_en = 1'b1;
	int                   stall_left = 0;
	int                   hold_len = 0;
	logic                 hold_on = 1'b0;

	bracket_nesting_checker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol      (symbol),
		.line_start  (line_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mismatch    (mismatch),
		.line_halted (line_halted),
		.total_score (total_score),
		.overflow    (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] opener_of(logic [1:0] k);
		case (k)
			KIND_ROUND:  return CH_OPEN_ROUND;
			KIND_SQUARE: return CH_OPEN_SQUARE;
			KIND_CURLY:  return CH_OPEN_CURLY;
			default:     return CH_OPEN_ANGLE;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(logic [1:0] k);
		case (k)
			KIND_ROUND:  return CH_CLOSE_ROUND;
			KIND_SQUARE: return CH_CLOSE_SQUARE;
			KIND_CURLY:  return CH_CLOSE_CURLY;
			default:     return CH_CLOSE_ANGLE;
		endcase
	endfunction

	function automatic int draw_gap(bit en);
		if (!en || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic void predict_bracket_result(logic [7:0] sym, logic ls);
		logic             is_open;
		logic             is_close;
		logic             bad;
		logic [1:0]       k;
		logic [SCORE_W:0] sum;
		line_result_t     r;
		is_open = 1'b0;
		is_close = 1'b0;
		bad = 1'b0;
		k = KIND_ROUND;
		case (sym)
			CH_OPEN_ROUND: begin
				is_open = 1'b1;
				k = KIND_ROUND;
			end
			CH_OPEN_SQUARE: begin
				is_open = 1'b1;
				k = KIND_SQUARE;
			end
			CH_OPEN_CURLY: begin
				is_open = 1'b1;
				k = KIND_CURLY;
			end
			CH_OPEN_ANGLE: begin
				is_open = 1'b1;
				k = KIND_ANGLE;
			end
			CH_CLOSE_ROUND: begin
				is_close = 1'b1;
				k = KIND_ROUND;
			end
			CH_CLOSE_SQUARE: begin
				is_close = 1'b1;
				k = KIND_SQUARE;
			end
			CH_CLOSE_CURLY: begin
				is_close = 1'b1;
				k = KIND_CURLY;
			end
			CH_CLOSE_ANGLE: begin
				is_close = 1'b1;
				k = KIND_ANGLE;
			end
			default: begin
			end
		endcase
		if (ls) begin
			stack_fill = 0;
			line_dead = 1'b0;
		end
		if (!line_dead) begin
			if (is_open) begin
				if (stack_fill < STACK_DEPTH_DEF) begin
					kind_stack[stack_fill] = k;
					stack_fill++;
				end else begin
					stack_ovf = 1'b1;
				end
			end else if (is_close) begin
				if (stack_fill == 0) begin
					bad = 1'b1;
				end else begin
					stack_fill--;
					bad = (kind_stack[stack_fill] != k);
				end
				if (bad) begin
					sum = {1'b0, score_acc} + (SCORE_W + 1)'(weight_q[k]);
					score_acc = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
					line_dead = 1'b1;
				end
			end
		end
		r.mismatch = bad;
		r.line_halted = line_dead;
		r.total_score = score_acc;
		r.overflow = stack_ovf;
		pending_results.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [SCORE_W-1:0] got,
		logic [SCORE_W-1:0] want);
		err_cnt++;
		$display("ERROR result %0d %s: got %0h, expected %0h", beats_checked, what, got, want);
	endtask

	task automatic check_result();
		line_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending", total_score, '0);
			return;
		end
		want = pending_results.pop_front();
		if (mismatch !== want.mismatch)
			report_mismatch("mismatch", SCORE_W'(mismatch), SCORE_W'(want.mismatch));
		if (line_halted !== want.line_halted)
			report_mismatch("line_halted", SCORE_W'(line_halted), SCORE_W'(want.line_halted));
		if (total_score !== want.total_score)
			report_mismatch("total_score", total_score, want.total_score);
		if (overflow !== want.overflow)
			report_mismatch("overflow", SCORE_W'(overflow), SCORE_W'(want.overflow));
		beats_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_result();
			stall_left = draw_gap(snk_idle_en);
		end else if (arst_n && out_valid && stall_left > 0) begin
			stall_left--;
		end
		out_stall <= hold_on || (stall_left > 0);
	end

	initial begin
		forever begin
			wait (hold_len > 0);
			@(posedge clk);
			hold_on <= 1'b1;
			repeat (hold_len) @(posedge clk);
			hold_on <= 1'b0;
			hold_len = 0;
		end
	end

	task automatic send_symbol(logic [7:0] sym, logic ls);
		int gap;
		gap = draw_gap(src_idle_en);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		symbol     <= sym;
		line_start <= ls;
		do @(posedge clk); while (in_stall);
		predict_bracket_result(sym, ls);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		weight_q[idx] = val;
	endtask

	task automatic set_weights(logic [WEIGHT_W-1:0] w_round, logic [WEIGHT_W-1:0] w_square,
		logic [WEIGHT_W-1:0] w_curly, logic [WEIGHT_W-1:0] w_angle);
		write_reg(REG_WEIGHT_ROUND, w_round);
		write_reg(REG_WEIGHT_SQUARE, w_square);
		write_reg(REG_WEIGHT_CURLY, w_curly);
		write_reg(REG_WEIGHT_ANGLE, w_angle);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_line();
		logic [1:0] open_kinds [$];
		int         len;
		int         pick;
		logic [1:0] k;
		logic       ls;
		len = $urandom_range(1, 30);
		ls = 1'b1;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			k = 2'($urandom_range(0, 3));
			if (pick < 40) begin
				send_symbol(opener_of(k), ls);
				open_kinds.push_back(k);
			end else if (pick < 78 && open_kinds.size() != 0) begin
				send_symbol(closer_of(open_kinds.pop_back()), ls);
			end else if (pick < 86) begin
				send_symbol(closer_of(k), ls);
			end else begin
				send_symbol(8'($urandom_range(0, 255)), ls);
			end
			ls = 1'b0;
		end
		if ($urandom_range(0, 1) == 1)
			while (open_kinds.size() != 0)
				send_symbol(closer_of(open_kinds.pop_back()), 1'b0);
	endtask

	task automatic test_directed();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		send_symbol(CH_OPEN_ROUND, 1'b1);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		send_symbol(CH_OPEN_SQUARE, 1'b0);
		send_symbol(CH_OPEN_CURLY, 1'b0);
		send_symbol(CH_OPEN_ANGLE, 1'b0);
		send_symbol(CH_CLOSE_ANGLE, 1'b0);
		send_symbol(CH_CLOSE_CURLY, 1'b0);
		send_symbol(CH_CLOSE_SQUARE, 1'b0);
		send_symbol(CH_CLOSE_SQUARE, 1'b0);
		send_symbol(CH_OPEN_ROUND, 1'b0);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		send_symbol(CH_OPEN_CURLY, 1'b1);
		send_symbol(8'h00, 1'b0);
		send_symbol(CH_CLOSE_ANGLE, 1'b0);
		send_symbol(8'hFF, 1'b1);
		send_symbol(CH_CLOSE_CURLY, 1'b1);
		send_symbol(CH_OPEN_ANGLE, 1'b1);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		send_symbol(CH_OPEN_SQUARE, 1'b1);
		send_symbol(CH_OPEN_ROUND, 1'b1);
		send_symbol(8'hAA, 1'b0);
		send_symbol(8'h55, 1'b0);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		wait_idle();
	endtask

	task automatic test_random();
		int first;
		int phase;
		first = beats_sent;
		phase = 0;
		while (beats_sent - first < 800) begin
			if ((beats_sent - first) / 200 != phase) begin
				phase = (beats_sent - first) / 200;
				wait_idle();
				if (phase == 1)
					set_weights('0, '0, '0, '0);
				else if (phase == 2)
					set_weights('1, '1, '1, '1);
				else
					set_weights(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			end
			src_idle_en = ($urandom_range(0, 4) != 0);
			snk_idle_en = ($urandom_range(0, 4) != 0);
			send_random_line();
			if ($urandom_range(0, 15) == 0)
				wait_idle();
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		logic [1:0] k;
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		// hold the output side so the block backs up into its input
		hold_len = 120;
		send_symbol(CH_OPEN_CURLY, 1'b1);
		for (int i = 0; i < 60; i++) begin
			k = 2'($urandom_range(0, 3));
			send_symbol(($urandom_range(0, 1) == 1) ? opener_of(k) : closer_of(k),
				($urandom_range(0, 9) == 0));
		end
		wait_idle();
	endtask

	task automatic test_full_depth();
		logic [1:0] kinds [$];
		logic [1:0] k;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
			k = 2'($urandom_range(0, 3));
			kinds.push_back(k);
			send_symbol(opener_of(k), i == 0);
		end
		while (kinds.size() != 0)
			send_symbol(closer_of(kinds.pop_back()), 1'b0);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		wait_idle();
	endtask

	task automatic test_overflow();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		for (int i = 0; i < STACK_DEPTH_DEF - 1; i++)
			send_symbol(CH_OPEN_ROUND, i == 0);
		send_symbol(CH_OPEN_SQUARE, 1'b0);
		send_symbol(CH_OPEN_CURLY, 1'b0);
		send_symbol(CH_OPEN_ANGLE, 1'b0);
		send_symbol(CH_CLOSE_CURLY, 1'b0);
		send_symbol(CH_OPEN_ROUND, 1'b0);
		send_symbol(CH_CLOSE_ROUND, 1'b1);
		send_symbol(CH_OPEN_ROUND, 1'b1);
		send_symbol(CH_CLOSE_ROUND, 1'b0);
		wait_idle();
	endtask

	task automatic test_max_weights();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		set_weights('1, '1, '1, '1);
		for (int i = 0; i < 24; i++)
			send_symbol(closer_of(2'($urandom_range(0, 3))), 1'b1);
		wait_idle();
		set_weights(16'd1, 16'd0, 16'd2, 16'd1);
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		for (int i = 0; i < 8; i++)
			send_symbol(closer_of(2'($urandom_range(0, 3))), 1'b1);
		wait_idle();
	endtask

	initial begin
		weight_q[REG_WEIGHT_ROUND]  = WEIGHT_ROUND_RST;
		weight_q[REG_WEIGHT_SQUARE] = WEIGHT_SQUARE_RST;
		weight_q[REG_WEIGHT_CURLY]  = WEIGHT_CURLY_RST;
		weight_q[REG_WEIGHT_ANGLE]  = WEIGHT_ANGLE_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_full_depth();
		test_overflow();
		test_max_weights();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("bracket_nesting_checker test passed");
		else
			$display("bracket_nesting_checker test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("bracket_nesting_checker test failed");
		$finish;
	end

endmodule
